### src/vcodec_pkg.sv
`default_nettype none

package vcodec_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned MAX_GROUPS = 5;
  localparam int unsigned CNT_W      = 3;

  typedef enum logic [1:0] {
    STAT_BYTE    = 2'd0,
    STAT_VALUE   = 2'd1,
    STAT_CORRUPT = 2'd2
  } status_e;

  // encoder view toward the output stage
  typedef struct packed {
    logic              busy;
    logic [BYTE_W-1:0] data;
    logic              last;
  } enc_out_t;

  // decoder result for the accepted byte
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [VALUE_W-1:0] value;
  } dec_out_t;

endpackage

`default_nettype wire

### src/vcodec_enc.sv
`default_nettype none

module vcodec_enc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          advance_i,
  input  wire logic [vcodec_pkg::VALUE_W-1:0] value_i,
  output vcodec_pkg::enc_out_t               enc_o
);
  import vcodec_pkg::*;

  logic               busy_q, busy_d;
  logic [VALUE_W-1:0] rest_q, rest_d;
  logic [VALUE_W-1:0] src;
  logic               more;

  // low group of the remaining bits goes out; the rest shifts down 7
  assign src  = busy_q ? rest_q : value_i;
  assign more = |src[VALUE_W-1:GROUP_BITS];

  always_comb begin
    busy_d = busy_q;
    rest_d = rest_q;
    if (start_i || advance_i) begin
      busy_d = more;
      rest_d = {{GROUP_BITS{1'b0}}, src[VALUE_W-1:GROUP_BITS]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
  end

  assign enc_o.busy = busy_q;
  assign enc_o.data = {src[GROUP_BITS-1:0], more};
  assign enc_o.last = !more;

endmodule

`default_nettype wire

### src/vcodec_dec.sv
`default_nettype none

module vcodec_dec (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic [vcodec_pkg::BYTE_W-1:0] byte_i,
  output vcodec_pkg::dec_out_t              dec_o
);
  import vcodec_pkg::*;

  logic [VALUE_W-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [GROUP_BITS-1:0] grp;
  logic [VALUE_W-1:0]    merged;

  assign grp = byte_i[BYTE_W-1:1];

  // each group lands in its own 7-bit lane; the fifth keeps 4 bits
  always_comb begin
    merged = acc_q;
    case (cnt_q)
      3'd0:    merged[6:0]   = grp;
      3'd1:    merged[13:7]  = grp;
      3'd2:    merged[20:14] = grp;
      3'd3:    merged[27:21] = grp;
      3'd4:    merged[31:28] = grp[3:0];
      default: merged        = acc_q;
    endcase
  end

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    dec_o.valid  = 1'b0;
    dec_o.status = STAT_VALUE;
    dec_o.value  = merged;
    if (en_i) begin
      if (cnt_q >= CNT_W'(MAX_GROUPS)) begin
        acc_d        = '0;
        cnt_d        = '0;
        dec_o.valid  = 1'b1;
        dec_o.status = STAT_CORRUPT;
        dec_o.value  = '0;
      end else if (!byte_i[0]) begin
        acc_d       = '0;
        cnt_d       = '0;
        dec_o.valid = 1'b1;
      end else begin
        acc_d = merged;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_GROUPS))
    else $error("group count beyond five");
`endif

endmodule

`default_nettype wire

### src/packed_uint32_varint_codec.sv
// Varint codec for 32-bit unsigned values in 7-bit groups, low group first;
// each byte carries its group in bits 7..1 and a more flag in bit 0.
// cfg_wdata_i written with 1 selects encode, 0 decode (reset: decode).
// Encode: one request on value_in_i yields 1 to 5 bytes, shifted out 7
// bits at a time, one per cycle unless the output stalls; the next request
// waits until the last byte is in the output register and it frees up.
// Decode: one byte per cycle unless the output stalls; a clear more flag
// yields the value, a sixth byte in one value yields a corrupt status.
// Throughput is bounded by the single output register and downstream ready.
`default_nettype none

module packed_uint32_varint_codec (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [vcodec_pkg::VALUE_W-1:0] value_in_i,
  input  wire logic [vcodec_pkg::BYTE_W-1:0]  byte_in_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [vcodec_pkg::BYTE_W-1:0]  byte_out_o,
  output      logic [vcodec_pkg::VALUE_W-1:0] value_out_o,
  output      logic [1:0]                    status_o,
  output      logic                          last_of_run_o
);
  import vcodec_pkg::*;

  logic               dir_q;
  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic [VALUE_W-1:0] value_q, value_d;
  status_e            status_q, status_d;
  logic               last_q, last_d;

  logic     out_free;
  logic     accept;
  enc_out_t enc;
  dec_out_t dec;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = out_free && !enc.busy;
  assign accept     = in_valid_i && in_ready_o;

  vcodec_enc u_enc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && dir_q),
    .advance_i (enc.busy && out_free),
    .value_i   (value_in_i),
    .enc_o     (enc)
  );

  vcodec_dec u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept && !dir_q),
    .byte_i (byte_in_i),
    .dec_o  (dec)
  );

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    value_d     = value_q;
    status_d    = status_q;
    last_d      = last_q;
    if (enc.busy && out_free || accept && dir_q) begin
      out_valid_d = 1'b1;
      byte_d      = enc.data;
      value_d     = '0;
      status_d    = STAT_BYTE;
      last_d      = enc.last;
    end else if (dec.valid) begin
      out_valid_d = 1'b1;
      byte_d      = '0;
      value_d     = dec.value;
      status_d    = dec.status;
      last_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    value_q  <= value_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign byte_out_o    = byte_q;
  assign value_out_o   = value_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

`ifndef SYNTHESIS
  a_busy_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc.busy |-> out_valid_q)
    else $error("encoder running without a byte in the output register");

  a_not_last_is_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !last_q |-> status_q == STAT_BYTE)
    else $error("non-final result that is not an encoded byte");

  a_busy_is_encode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc.busy |-> dir_q)
    else $error("encoder busy in decode mode");

  a_no_dec_in_encode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec.valid |-> !dir_q && accept)
    else $error("decoder result without an accepted byte");
`endif

endmodule

`default_nettype wire

### verif/packed_uint32_varint_codec_tb.sv
`default_nettype none

module packed_uint32_varint_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vcodec_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic [BYTE_W-1:0]  enc_byte;
    logic [VALUE_W-1:0] dec_value;
    status_e            stat;
    logic               last;
  } codec_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [VALUE_W-1:0] value_in_i  = '0;
  logic [BYTE_W-1:0]  byte_in_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [BYTE_W-1:0]  byte_out_o;
  logic [VALUE_W-1:0] value_out_o;
  logic [1:0]         status_o;
  logic               last_of_run_o;

  // codec state as predicted
  logic               dir_q   = 1'b0;
  logic [VALUE_W-1:0] acc_q   = '0;
  logic [CNT_W-1:0]   grp_cnt = '0;

  codec_result_t due_results[$];

  int gap_pct      = 18;
  int stall_pct    = 18;
  int mismatch_cnt = 0;
  int checked_cnt  = 0;
  int enc_cnt      = 0;
  int dec_cnt      = 0;
  int corrupt_cnt  = 0;
  int cycle_cnt    = 0;

  packed_uint32_varint_codec dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_in_i   (value_in_i),
    .byte_in_i    (byte_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_out_o   (byte_out_o),
    .value_out_o  (value_out_o),
    .status_o     (status_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               due_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic note_mismatch(input string field, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
    if (mismatch_cnt < PRINT_CAP)
      $display("MISMATCH %s: got %h, expected %h (cycle %0d)", field, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  task automatic push_result(input logic [BYTE_W-1:0] b, input logic [VALUE_W-1:0] v,
                             input status_e st, input logic last);
    codec_result_t r;
    r.enc_byte  = b;
    r.dec_value = v;
    r.stat      = st;
    r.last      = last;
    due_results.push_back(r);
  endtask

  task automatic predict_codec(input logic [VALUE_W-1:0] v, input logic [BYTE_W-1:0] b);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] grp_w;
    logic [BYTE_W-1:0]  enc;
    if (dir_q) begin
      enc_cnt++;
      rest = v;
      do begin
        enc  = {rest[GROUP_BITS-1:0], 1'b0};
        rest = rest >> GROUP_BITS;
        push_result(enc | BYTE_W'(rest != 0), '0, STAT_BYTE, rest == 0);
      end while (rest != 0);
    end else begin
      dec_cnt++;
      if (grp_cnt >= MAX_GROUPS) begin
        // sixth byte of one value: dropped, state cleared
        acc_q   = '0;
        grp_cnt = '0;
        corrupt_cnt++;
        push_result('0, '0, STAT_CORRUPT, 1'b1);
      end else begin
        grp_w   = VALUE_W'(b[BYTE_W-1:1]);
        acc_q   = acc_q | (grp_w << (GROUP_BITS * grp_cnt));
        grp_cnt = grp_cnt + 1'b1;
        if (!b[0]) begin
          push_result('0, acc_q, STAT_VALUE, 1'b1);
          acc_q   = '0;
          grp_cnt = '0;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    codec_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        checked_cnt++;
        if (due_results.size() == 0) begin
          note_mismatch("unexpected result", value_out_o, '0);
        end else begin
          want = due_results.pop_front();
          if (byte_out_o !== want.enc_byte)
            note_mismatch("byte_out", VALUE_W'(byte_out_o), VALUE_W'(want.enc_byte));
          if (value_out_o !== want.dec_value)
            note_mismatch("value_out", value_out_o, want.dec_value);
          if (status_o !== want.stat)
            note_mismatch("status", VALUE_W'(status_o), VALUE_W'(want.stat));
          if (last_of_run_o !== want.last)
            note_mismatch("last_of_run", VALUE_W'(last_of_run_o), VALUE_W'(want.last));
        end
      end
      if (cfg_we_i)
        dir_q = cfg_wdata_i;
      if (in_valid_i && in_ready_o)
        predict_codec(value_in_i, byte_in_i);
    end
  end

  task automatic send_item(input logic [VALUE_W-1:0] v, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_in_i <= v;
    byte_in_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o)
      @(posedge clk_i);
  endtask

  // hold off new requests until every expected result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_direction(input logic d);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    v = $urandom;
    return v >> $urandom_range(0, VALUE_W);
  endfunction

  task automatic send_decode_run();
    int         pick;
    int         n_grp;
    logic [6:0] grp;
    pick = $urandom_range(99);
    if (pick < 70) begin
      n_grp = $urandom_range(1, MAX_GROUPS);
      for (int i = 0; i < n_grp; i++) begin
        grp = ($urandom_range(3) == 0) ? 7'h7f : 7'($urandom);
        send_item($urandom, {grp, 1'(i < n_grp - 1)});
      end
    end else if (pick < 85) begin
      for (int i = 0; i < MAX_GROUPS; i++)
        send_item($urandom, {7'($urandom), 1'b1});
      send_item($urandom, 8'($urandom));
    end else begin
      send_item($urandom, 8'($urandom));
    end
  endtask

  task automatic test_decode_directed();
    write_direction(1'b0);
    send_item('0, 8'h00);
    send_item('1, 8'hfe);
    send_item('0, 8'hff);
    send_item('0, 8'h02);
    // five groups, top group overflows past bit 31
    repeat (4) send_item('0, 8'hff);
    send_item('0, 8'hfe);
    // sixth byte is corrupt
    repeat (5) send_item('0, 8'hff);
    send_item('0, 8'hab);
    send_item('0, 8'h54);
  endtask

  task automatic test_encode_directed();
    logic [VALUE_W-1:0] vals[9];
    vals = '{32'h0, 32'h7f, 32'h80, 32'h3fff, 32'h4000,
             32'h0fffffff, 32'h10000000, 32'h80000000, 32'hffffffff};
    write_direction(1'b1);
    foreach (vals[i])
      send_item(vals[i], 8'($urandom));
  endtask

  task automatic test_direction_switch();
    write_direction(1'b0);
    send_item('0, 8'hff);
    send_item('0, 8'hff);
    write_direction(1'b1);
    send_item(32'h12345678, 8'h00);
    write_direction(1'b0);
    // resumes the interrupted value
    send_item('0, 8'h02);
  endtask

  task automatic test_random_decode();
    write_direction(1'b0);
    repeat (25) send_decode_run();
    drain_results();
    repeat (25) send_decode_run();
  endtask

  task automatic test_random_encode();
    write_direction(1'b1);
    repeat (100) send_item(rand_value(), 8'($urandom));
  endtask

  task automatic test_random_mixed();
    for (int phase = 0; phase < 6; phase++) begin
      write_direction(phase[0]);
      if (phase == 2 || phase == 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 18;
        stall_pct = 18;
      end
      if (phase[0])
        repeat (20) send_item(rand_value(), 8'($urandom));
      else
        repeat (8) send_decode_run();
    end
    gap_pct   = 18;
    stall_pct = 18;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_decode_directed();
    test_encode_directed();
    test_direction_switch();
    test_random_decode();
    test_random_encode();
    test_random_mixed();
    drain_results();
    $display("Encoded %0d values and decoded %0d bytes (%0d corrupt runs) in both directions,",
             enc_cnt, dec_cnt, corrupt_cnt);
    $display("with mid-value direction switches and random stalls; %0d results checked.",
             checked_cnt);
    if (mismatch_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/vcodec_pkg.sv
src/vcodec_enc.sv
src/vcodec_dec.sv
src/packed_uint32_varint_codec.sv
verif/packed_uint32_varint_codec_tb.sv
